### hdl/skf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skf_pkg
// Widths, register codes and fixed-point helpers shared by the scalar
// Kalman sample filter and its divider.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 32;
    localparam int REG_W     = 32;
    localparam int PRED_W    = FRAC_W + 1;
    localparam int DEN_W     = FRAC_W + 2;
    localparam int GAIN_W    = FRAC_W + 1;
    localparam int MUL_W     = 2 * GAIN_W;
    localparam int CNT_W     = $clog2(FRAC_W + 1);
    localparam int CFG_IDX_W = 2;
    localparam int ALIGN_L   = (FRAC_W >= REG_W) ? FRAC_W - REG_W : 0;
    localparam int ALIGN_R   = (FRAC_W >= REG_W) ? 0 : REG_W - FRAC_W;

    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [REG_W-1:0]     t_reg;
    typedef logic [FRAC_W-1:0]    t_frac;
    typedef logic [PRED_W-1:0]    t_pred;
    typedef logic [DEN_W-1:0]     t_den;
    typedef logic [GAIN_W-1:0]    t_gain;
    typedef logic [MUL_W-1:0]     t_prod;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PROCESS_NOISE     = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_MEASUREMENT_NOISE = t_cfg_idx'(1);

    localparam t_reg PROCESS_NOISE_RST     = t_reg'(42950);
    localparam t_reg MEASUREMENT_NOISE_RST = t_reg'(21474836);

    localparam t_gain GAIN_ONE = t_gain'(1) << FRAC_W;

    // register fraction (REG_W bits) to FRAC_W fraction bits, truncating
    function automatic t_frac align_reg(input t_reg v);
        logic [FRAC_W+REG_W-1:0] w;
        w = {{FRAC_W{1'b0}}, v};
        w = w << ALIGN_L;
        w = w >> ALIGN_R;
        return w[FRAC_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hdl/scalar_kalman_sample_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_sample_filter
// One-dimensional Kalman filter over unsigned samples, 32-bit fixed point.
// ----------------------------------------------------------------------------
// Each accepted sample gives one filtered sample. An accepted item passes the
// prediction and divider start steps, waits on the restoring divider that
// forms the gain (33 quotient bits at one per cycle, then its done flag), and
// then the multiply, estimate and done steps on one shared multiplier and the
// update logic load its result into the output register. The input is ready
// again only after that, so no new item is taken before the last is through;
// a result left waiting in the output register holds the next item only at its
// final step. The user must write noise registers through the configuration
// port only while no item is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module scalar_kalman_sample_filter (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  skf_pkg::t_sample    i_sample,
    output logic                o_valid,
    input  wire                 i_ready,
    output skf_pkg::t_sample    o_filtered,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  skf_pkg::t_cfg_idx   i_cfg_index,
    input  skf_pkg::t_reg       i_cfg_data
);
    import skf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRED  = 3'd1;
    localparam logic [2:0] S_DIVS  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MULC  = 3'd4;
    localparam logic [2:0] S_EST   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    t_reg       r_q, n_q;
    t_reg       r_r, n_r;
    logic       r_started, n_started;
    t_sample    r_est, n_est;
    t_frac      r_cov, n_cov;
    t_sample    r_sample, n_sample;
    t_sample    r_mag, n_mag;
    logic       r_neg, n_neg;
    t_pred      r_pred, n_pred;
    t_gain      r_gain, n_gain;
    t_prod      r_prod, n_prod;
    t_sample    r_out, n_out;
    logic       r_out_valid, n_out_valid;

    logic                w_div_start;
    logic                w_div_done;
    t_gain               w_div_quot;
    t_den                w_den;
    t_gain               w_mul_a;
    t_gain               w_mul_b;
    t_sample             w_corr;
    logic                w_rest;
    logic [FRAC_W+1:0]   w_cov_hi;

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_pred),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_filtered  = r_out;

    assign w_div_start = (r_state == S_DIVS);
    assign w_den       = DEN_W'(r_pred) + DEN_W'(align_reg(r_r));

    // shared multiplier: gain * |difference|, then (1 - gain) * predicted
    assign w_mul_a = (r_state == S_MULC) ? r_gain : GAIN_ONE - r_gain;
    assign w_mul_b = (r_state == S_MULC) ? GAIN_W'(r_mag) : GAIN_W'(r_pred);

    assign w_corr   = r_prod[FRAC_W +: SAMPLE_W];
    assign w_rest   = |r_prod[FRAC_W-1:0];
    assign w_cov_hi = r_prod[MUL_W-1:FRAC_W];

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_r         = r_r;
        n_started   = r_started;
        n_est       = r_est;
        n_cov       = r_cov;
        n_sample    = r_sample;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_pred      = r_pred;
        n_gain      = r_gain;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROCESS_NOISE:     n_q = i_cfg_data;
                CFG_MEASUREMENT_NOISE: n_r = i_cfg_data;
                default: ;
            endcase
        end

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sample = i_sample;
                    if (!r_started) begin
                        n_est     = '0;
                        n_cov     = '0;
                        n_started = 1'b1;
                    end
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                n_pred  = PRED_W'(r_cov) + PRED_W'(align_reg(r_q));
                n_neg   = r_sample < r_est;
                n_mag   = (r_sample < r_est) ? r_est - r_sample : r_sample - r_est;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_gain  = w_div_quot;
                    n_state = S_MULC;
                end
            end
            S_MULC: begin
                n_prod  = MUL_W'(w_mul_a) * MUL_W'(w_mul_b);
                n_state = S_EST;
            end
            S_EST: begin
                if (r_neg) begin
                    n_est = r_est - w_corr - SAMPLE_W'(w_rest);
                end else begin
                    n_est = r_est + w_corr;
                end
                n_prod  = MUL_W'(w_mul_a) * MUL_W'(w_mul_b);
                n_state = S_DONE;
            end
            S_DONE: begin
                n_cov = (|w_cov_hi[FRAC_W+1:FRAC_W]) ? '1 : w_cov_hi[FRAC_W-1:0];
                if (!r_out_valid || i_ready) begin
                    n_out       = r_est;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q         <= PROCESS_NOISE_RST;
            r_r         <= MEASUREMENT_NOISE_RST;
            r_started   <= 1'b0;
            r_est       <= '0;
            r_cov       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_q         <= n_q;
            r_r         <= n_r;
            r_started   <= n_started;
            r_est       <= n_est;
            r_cov       <= n_cov;
            r_out_valid <= n_out_valid;
        end
        r_sample <= n_sample;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_pred   <= n_pred;
        r_gain   <= n_gain;
        r_prod   <= n_prod;
        r_out    <= n_out;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after an accepted item");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the division step");

    a_gain_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MULC |-> r_gain <= GAIN_ONE)
        else $error("gain above one");

    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped");

    a_started_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_started)
        else $error("item in flight without started flag");

endmodule
`default_nettype wire

### hdl/skf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skf_div
// Restoring fractional divider: floor(num * 2^FRAC_W / den) for num <= den,
// one quotient bit per cycle, FRAC_W + 1 steps. A zero divisor gives zero.
// ----------------------------------------------------------------------------
module skf_div (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  skf_pkg::t_pred  i_num,
    input  skf_pkg::t_den   i_den,
    output logic            o_done,
    output skf_pkg::t_gain  o_quot
);
    import skf_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_den             r_rem, n_rem;
    t_den             r_den, n_den;
    t_gain            r_quot, n_quot;
    logic             r_zero, n_zero;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    always_comb begin
        w_trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        w_ge    = w_trial >= {1'b0, r_den};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        n_zero = r_zero;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = DEN_W'(i_num);
            n_den  = i_den;
            n_quot = '0;
            n_zero = (i_den == '0);
        end else if (r_busy) begin
            n_rem  = w_ge ? t_den'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
            n_quot = {r_quot[GAIN_W-2:0], w_ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(FRAC_W)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
        r_zero <= n_zero;
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;

endmodule
`default_nettype wire

### dv/skf_filter_checker.sv
// ----------------------------------------------------------------------------
// skf_filter_checker
// Watches the sample, result and register channels of the scalar Kalman
// sample filter. It keeps its own copy of the noise registers and the filter
// state, computes the filtered value for every accepted sample and compares
// each accepted result against the oldest outstanding value, in order.
// ----------------------------------------------------------------------------
module skf_filter_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_sample_valid,
    input  wire               i_sample_ready,
    input  skf_pkg::t_sample  i_sample,
    input  wire               i_result_valid,
    input  wire               i_result_ready,
    input  skf_pkg::t_sample  i_filtered,
    input  wire               i_cfg_valid,
    input  wire               i_cfg_ready,
    input  skf_pkg::t_cfg_idx i_cfg_index,
    input  skf_pkg::t_reg     i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    import skf_pkg::*;

    t_reg    process_noise;
    t_reg    measurement_noise;
    t_sample estimate;
    t_frac   covariance;
    bit      started;
    t_sample expected_filtered[$];

    task automatic report_mismatch(input string what);
        if (o_errors < 200) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
        o_errors++;
    endtask

    // One filter step; registers carry 32 fraction bits, same as the state.
    function automatic t_sample kalman_update(input t_sample z);
        logic [32:0] predicted;
        logic [33:0] denom;
        logic [95:0] quotient;
        logic [32:0] gain;
        logic [15:0] delta;
        logic [63:0] scaled;
        logic [31:0] step;
        logic [79:0] cov_prod;
        logic [47:0] next_cov;
        if (!started) begin
            estimate   = '0;
            covariance = '0;
            started    = 1'b1;
        end
        predicted = {1'b0, covariance} + {1'b0, process_noise};
        denom     = {1'b0, predicted} + {2'b0, measurement_noise};
        if (denom == '0) begin
            gain = '0;
        end else begin
            quotient = ({63'b0, predicted} << 32) / {62'b0, denom};
            gain     = quotient[32:0];
        end
        if (z >= estimate) begin
            delta    = z - estimate;
            scaled   = {31'b0, gain} * {48'b0, delta};
            step     = scaled[63:32];
            estimate = estimate + step[15:0];
        end else begin
            delta    = estimate - z;
            scaled   = {31'b0, gain} * {48'b0, delta};
            step     = scaled[63:32] + (scaled[31:0] != '0);
            estimate = estimate - step[15:0];
        end
        cov_prod = {47'b0, 33'h1_0000_0000 - gain} * {47'b0, predicted};
        next_cov = cov_prod[79:32];
        covariance = (next_cov > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : next_cov[31:0];
        return estimate;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_sample want;
        if (!i_rst_n) begin
            process_noise     = PROCESS_NOISE_RST;
            measurement_noise = MEASUREMENT_NOISE_RST;
            estimate          = '0;
            covariance        = '0;
            started           = 1'b0;
            expected_filtered.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE:     process_noise = i_cfg_data;
                    CFG_MEASUREMENT_NOISE: measurement_noise = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result_valid && i_result_ready) begin
                if (expected_filtered.size() == 0) begin
                    report_mismatch($sformatf("unexpected filtered %h", i_filtered));
                end else begin
                    want = expected_filtered.pop_front();
                    if (i_filtered !== want) begin
                        report_mismatch($sformatf("filtered %h, expected %h",
                                                  i_filtered, want));
                    end
                end
            end
            if (i_sample_valid && i_sample_ready) begin
                expected_filtered.push_back(kalman_update(i_sample));
            end
        end
        o_pending = expected_filtered.size();
    end

endmodule

### dv/scalar_kalman_sample_filter_test.sv
// ----------------------------------------------------------------------------
// scalar_kalman_sample_filter_test
// Drives samples and noise register writes into the scalar Kalman sample
// filter: a directed opening over extreme samples and noise settings, then
// random phases with new noise settings, bursty input and a stalling output.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module scalar_kalman_sample_filter_test;
    import skf_pkg::*;

    localparam t_cfg_idx CFG_SPARE_A = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SPARE_B = t_cfg_idx'(3);
    localparam int       SAMPLE_TARGET = 1100;
    localparam int       HOLD_CYCLES   = 400;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_sample  i_sample;
    logic     o_valid;
    logic     i_ready;
    t_sample  o_filtered;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index;
    t_reg     i_cfg_data;

    int       errors;
    int       pending;
    int       rx_mode;
    bit       hold_go;
    t_sample  directed_q[$];

    scalar_kalman_sample_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_filtered  (o_filtered),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    skf_filter_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_valid),
        .i_sample_ready (o_ready),
        .i_sample       (i_sample),
        .i_result_valid (o_valid),
        .i_result_ready (i_ready),
        .i_filtered     (o_filtered),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Leaves valid high; the caller drops it unless the next item follows.
    task automatic send_sample(input t_sample value);
        i_valid  = 1'b1;
        i_sample = value;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_directed();
        foreach (directed_q[k]) begin
            send_sample(directed_q[k]);
        end
        i_valid = 1'b0;
    endtask

    task automatic write_reg(input t_cfg_idx index, input t_reg value);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic t_reg pick_noise();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return t_reg'(1);
            2:       return '1;
            3:       return t_reg'($urandom);
            4:       return t_reg'($urandom_range(0, 65535));
            5:       return $urandom_range(0, 1) ? PROCESS_NOISE_RST : MEASUREMENT_NOISE_RST;
            default: return t_reg'($urandom) >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_sample pick_sample(input t_sample level);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_sample'($urandom);
            4, 5, 6, 7: return level + t_sample'($urandom_range(0, 64)) - t_sample'(32);
            8:          return '0;
            default:    return '1;
        endcase
    endfunction

    // output side: own stall pattern plus a long hold-off on request
    initial begin : receiver
        int  hold_left;
        bit  hold_seen;
        bit  ready_next;
        hold_left = 0;
        hold_seen = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go != hold_seen) begin
                hold_seen = hold_go;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                case (rx_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = $urandom_range(0, 1);
                    default: ready_next = ($urandom_range(0, 7) == 0);
                endcase
            end
            i_ready = ready_next;
        end
    end

    initial begin : stimulus
        int      sent;
        int      phase;
        int      phase_len;
        int      gap_max;
        int      gap;
        int      burst_left;
        t_sample level;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PROCESS_NOISE;
        i_cfg_data  = '0;
        rx_mode     = 0;
        hold_go     = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset noise values; first sample starts the filter
        directed_q = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
                       16'h0001, 16'hAAAA, 16'h5555};
        send_directed();
        // both noise terms zero: the covariance drops to zero, then the gain is zero
        wait_drained();
        write_reg(CFG_PROCESS_NOISE, '0);
        write_reg(CFG_MEASUREMENT_NOISE, '0);
        directed_q = '{16'h1234, 16'hFFFF};
        send_directed();
        // no measurement noise: gain of exactly one
        wait_drained();
        write_reg(CFG_PROCESS_NOISE, 32'h8000_0000);
        directed_q = '{16'h4321, 16'h0000};
        send_directed();
        wait_drained();
        write_reg(CFG_PROCESS_NOISE, '1);
        write_reg(CFG_MEASUREMENT_NOISE, '1);
        directed_q = '{16'hFFFF, 16'h0000, 16'h7FFF};
        send_directed();
        // writes past the register list are dropped
        wait_drained();
        write_reg(CFG_SPARE_A, t_reg'($urandom));
        write_reg(CFG_SPARE_B, t_reg'($urandom));
        directed_q = '{16'h00FF, 16'hFF00};
        send_directed();
        wait_drained();
        write_reg(CFG_PROCESS_NOISE, t_reg'(1));
        write_reg(CFG_MEASUREMENT_NOISE, t_reg'(1));
        directed_q = '{16'hC3C3, 16'h3C3C};
        send_directed();

        sent  = 0;
        phase = 0;
        while (sent < SAMPLE_TARGET) begin
            wait_drained();
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_PROCESS_NOISE, pick_noise());
                write_reg(CFG_MEASUREMENT_NOISE, pick_noise());
            end else begin
                write_reg(CFG_MEASUREMENT_NOISE, pick_noise());
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(CFG_PROCESS_NOISE, pick_noise());
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, t_reg'($urandom));
            end
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase
            rx_mode    = $urandom_range(0, 2);
            level      = t_sample'($urandom);
            phase_len  = $urandom_range(20, 120);
            burst_left = $urandom_range(1, 20);
            if (phase == 2 || phase == 7 || $urandom_range(0, 9) == 0) begin
                hold_go = ~hold_go;
            end
            for (int k = 0; k < phase_len; k++) begin
                send_sample(pick_sample(level));
                sent++;
                if (burst_left == 0) begin
                    gap = $urandom_range(0, gap_max);
                    if (gap > 0) begin
                        i_valid = 1'b0;
                        repeat (gap) @(negedge i_clk);
                    end
                    burst_left = $urandom_range(1, 20);
                end else begin
                    burst_left--;
                end
            end
            i_valid = 1'b0;
            phase++;
        end

        wait_drained();
        repeat (60) @(negedge i_clk);
        if (errors == 0) begin
            $display("scalar_kalman_sample_filter_test OK");
        end else begin
            $display("scalar_kalman_sample_filter_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("scalar_kalman_sample_filter_test NOT OK");
        $finish;
    end

endmodule
